// ===== src/ps2mt_pkg.sv =====
// shared types and constants for the ps2 mouse packet tracker
package ps2mt_pkg;

  // width of the internal position accumulators (8 to 32)
  localparam int POS_WIDTH = 16;
  // width of the position fields on the result channel
  localparam int OUT_POS_W = 16;
  localparam int BTN_W     = 3;
  localparam int BYTE_W    = 8;

  localparam logic [BYTE_W-1:0] SYNC_BIT    = 8'h08;
  localparam logic [BYTE_W-1:0] BUTTON_MASK = 8'h07;
  localparam logic [POS_WIDTH-1:0] POS_MAX  = {POS_WIDTH{1'b1}};

  // packet byte phase
  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_DX   = 2'd1,
    PH_DY   = 2'd2
  } phase_t;

  // one result item
  typedef struct packed {
    logic [BTN_W-1:0]     buttons;
    logic [OUT_POS_W-1:0] pos_x;
    logic [OUT_POS_W-1:0] pos_y;
  } result_t;

  // add a signed byte delta to a position and clamp to [0, POS_MAX]
  function automatic logic [POS_WIDTH-1:0] add_clamp(input logic [POS_WIDTH-1:0] pos,
                                                     input logic [POS_WIDTH+1:0] delta);
    logic [POS_WIDTH+1:0] sum;
    sum = {2'b00, pos} + delta;
    if (sum[POS_WIDTH+1]) begin
      return '0;
    end else if (sum[POS_WIDTH]) begin
      return POS_MAX;
    end else begin
      return sum[POS_WIDTH-1:0];
    end
  endfunction

  // low bits of a position as carried on the result channel
  function automatic logic [OUT_POS_W-1:0] to_out(input logic [POS_WIDTH-1:0] pos);
    logic [POS_WIDTH+OUT_POS_W-1:0] ext;
    ext = {{OUT_POS_W{1'b0}}, pos};
    return ext[OUT_POS_W-1:0];
  endfunction

endpackage

// ===== src/ps2_mouse_packet_tracker_core.sv =====
// top level of the ps2 mouse three-byte packet tracker
//
// Usage: feed the bytes received from the mouse on the in_ channel, one byte
// per item. Bytes form three-byte packets: a header (bit 3 set, buttons in
// bits 2:0), an x delta and a y delta, both signed. A header byte without the
// sync bit is dropped. On each completed packet one item appears on the out_
// channel with the buttons and the updated x/y position, clamped at zero and
// saturated at the top of the position range (y moves opposite to dy).
// A packet's last byte goes through the input register, then the result
// register, and waits in the input register while a stalled item holds the
// result register. Throughput: one byte per cycle while the result register
// is free; the whole update is one pass of logic between the two registers.
// Reset (rst_n low, synchronous) clears both registers, the packet phase and
// the positions. When the receiver stalls, the result register holds its item
// and the input register takes one more byte; after that in_ready drops until
// the result is taken, whether or not the waiting byte would give a result.
module ps2_mouse_packet_tracker_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ps2mt_pkg::BYTE_W-1:0]        in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ps2mt_pkg::BTN_W-1:0]         out_buttons,
  output logic [ps2mt_pkg::OUT_POS_W-1:0]     out_pos_x,
  output logic [ps2mt_pkg::OUT_POS_W-1:0]     out_pos_y
);

  logic                         in_valid_r, in_valid_nxt;
  logic [ps2mt_pkg::BYTE_W-1:0] in_byte_r, in_byte_nxt;
  logic                         advance;
  logic                         slot_free;
  logic                         res_valid;
  ps2mt_pkg::result_t           res;
  ps2mt_pkg::result_t           out_data;

  // the held byte moves on when the result slot can take its result
  assign advance  = in_valid_r && slot_free;
  assign in_ready = !in_valid_r || advance;

  // input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_rx_byte;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
  end

  // packet tracking
  ps2mt_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  ps2mt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .free      (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_buttons = out_data.buttons;
  assign out_pos_x   = out_data.pos_x;
  assign out_pos_y   = out_data.pos_y;

endmodule

// ===== src/ps2mt_tracker.sv =====
// packet phase tracking and position accumulation for one byte per step
module ps2mt_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [ps2mt_pkg::BYTE_W-1:0]  rx_byte,
  output logic                          res_valid,
  output ps2mt_pkg::result_t            res
);

  ps2mt_pkg::phase_t phase_r, phase_nxt;
  logic [ps2mt_pkg::BTN_W-1:0]     held_buttons_r, held_buttons_nxt;
  logic [ps2mt_pkg::BYTE_W-1:0]    held_dx_r, held_dx_nxt;
  logic [ps2mt_pkg::POS_WIDTH-1:0] cur_x_r, cur_x_nxt;
  logic [ps2mt_pkg::POS_WIDTH-1:0] cur_y_r, cur_y_nxt;
  logic [ps2mt_pkg::BTN_W-1:0]     cur_buttons_r, cur_buttons_nxt;

  logic [ps2mt_pkg::POS_WIDTH+1:0] dx_ext;
  logic [ps2mt_pkg::POS_WIDTH+1:0] dy_neg;
  logic [ps2mt_pkg::POS_WIDTH-1:0] new_x;
  logic [ps2mt_pkg::POS_WIDTH-1:0] new_y;
  logic                            sync_ok;

  // deltas sign extended; y is subtracted (screen y inverted)
  assign dx_ext  = {{(ps2mt_pkg::POS_WIDTH-6){held_dx_r[7]}}, held_dx_r};
  assign dy_neg  = '0 - {{(ps2mt_pkg::POS_WIDTH-6){rx_byte[7]}}, rx_byte};
  assign new_x   = ps2mt_pkg::add_clamp(cur_x_r, dx_ext);
  assign new_y   = ps2mt_pkg::add_clamp(cur_y_r, dy_neg);
  assign sync_ok = |(rx_byte & ps2mt_pkg::SYNC_BIT);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        ps2mt_pkg::PH_DX: phase_nxt = ps2mt_pkg::PH_DY;
        ps2mt_pkg::PH_DY: phase_nxt = ps2mt_pkg::PH_HEAD;
        default:          phase_nxt = sync_ok ? ps2mt_pkg::PH_DX : ps2mt_pkg::PH_HEAD;
      endcase
    end
  end

  // data updates and result
  always_comb begin
    held_buttons_nxt = held_buttons_r;
    held_dx_nxt      = held_dx_r;
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    cur_buttons_nxt  = cur_buttons_r;
    res_valid        = 1'b0;
    case (phase_r)
      ps2mt_pkg::PH_DX: begin
        if (step) begin
          held_dx_nxt = rx_byte;
        end
      end
      ps2mt_pkg::PH_DY: begin
        if (step) begin
          cur_x_nxt       = new_x;
          cur_y_nxt       = new_y;
          cur_buttons_nxt = held_buttons_r;
          res_valid       = 1'b1;
        end
      end
      default: begin
        if (step && sync_ok) begin
          held_buttons_nxt = rx_byte[ps2mt_pkg::BTN_W-1:0];
        end
      end
    endcase
  end

  assign res.buttons = cur_buttons_nxt;
  assign res.pos_x   = ps2mt_pkg::to_out(cur_x_nxt);
  assign res.pos_y   = ps2mt_pkg::to_out(cur_y_nxt);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ps2mt_pkg::PH_HEAD;
      held_buttons_r <= '0;
      held_dx_r      <= '0;
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      cur_buttons_r  <= '0;
    end else begin
      phase_r        <= phase_nxt;
      held_buttons_r <= held_buttons_nxt;
      held_dx_r      <= held_dx_nxt;
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
      cur_buttons_r  <= cur_buttons_nxt;
    end
  end

endmodule

// ===== src/ps2mt_out_reg.sv =====
// result register on the output channel
module ps2mt_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ps2mt_pkg::result_t load_data,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output ps2mt_pkg::result_t out_data
);

  logic               valid_r, valid_nxt;
  ps2mt_pkg::result_t data_r, data_nxt;

  // slot can take a new item if empty or being drained now
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/ps2mt_checker.sv =====
// port level checks for the packet tracker, bound to the top level
module ps2mt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ps2mt_pkg::BTN_W-1:0]     out_buttons,
  input logic [ps2mt_pkg::OUT_POS_W-1:0] out_pos_x,
  input logic [ps2mt_pkg::OUT_POS_W-1:0] out_pos_y
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_buttons)
      && $stable(out_pos_x) && $stable(out_pos_y))
    else $error("result changed while stalled");

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new result goes back to an accepted byte that did not wait in the input register
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted byte two cycles before");

  // with the result channel empty the input is never blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while result channel empty");

endmodule

bind ps2_mouse_packet_tracker_core ps2mt_checker u_ps2mt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_buttons (out_buttons),
  .out_pos_x   (out_pos_x),
  .out_pos_y   (out_pos_y)
);
